>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/psrw_pkg.sv
package psrw_pkg;

   localparam int RUN_MAX       = 256;
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int RUN_W         = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;

   // Item opcodes; code 3 is unused and ignored.
   typedef enum logic [1:0] {
      OP_PALETTE = 2'd0,
      OP_LINE    = 2'd1,
      OP_PIXEL   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_X_OFFSET      = 2'd2,
      CSR_Y_OFFSET      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  palette_slot;
      logic [15:0] palette_color;
      logic [15:0] frame_x;
      logic [15:0] frame_y;
      logic [15:0] line_row;
      logic [15:0] line_width;
      logic [7:0]  transparent_index;
      logic [7:0]  background_index;
      logic        restore_background;
      logic        has_transparency;
      logic [7:0]  pixel_value;
   } req_type;

   typedef struct packed {
      logic [10:0] write_x;
      logic [10:0] write_y;
      logic [15:0] color;
      logic        run_first;
   } rsp_type;

   // Per-item decision from the line controller.
   typedef struct packed {
      logic        draw;
      logic        in_range;
      logic [7:0]  color_index;
      logic [10:0] write_x;
      logic [10:0] write_y;
      logic        run_first;
   } pix_type;

endpackage

>>> sv/psrw_palette_ram.sv
module psrw_palette_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/psrw_line_ctrl.sv
`include "assert_macros.svh"

module psrw_line_ctrl
   import psrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   output pix_type     pix
);

   // configuration
   logic [11:0] screen_width_ff;
   logic [11:0] screen_height_ff;
   logic [10:0] x_offset_ff;
   logic [10:0] y_offset_ff;

   // line state
   logic             line_visible_ff, line_visible_in;
   logic [11:0]      base_x_ff, base_x_in;
   logic [11:0]      panel_y_ff, panel_y_in;
   logic [11:0]      width_ff, width_in;
   logic [11:0]      pos_ff, pos_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             skip_ff, skip_in;
   logic             subst_ff, subst_in;
   logic [7:0]       key_ff, key_in;
   logic [7:0]       fill_ff, fill_in;

   // line-start arithmetic
   logic [16:0] line_base;
   logic [17:0] line_y;
   logic [17:0] span_end;
   logic        clip;
   logic        line_ok;
   logic [11:0] width_cut;

   // pixel path
   logic        pix_live;
   logic [7:0]  idx_sub;
   logic        transparent;
   logic [12:0] col;

   always_comb begin
      line_base = 17'(x_offset_ff) + 17'(req.frame_x);
      line_y    = 18'(y_offset_ff) + 18'(req.frame_y) + 18'(req.line_row);
      span_end  = 18'(req.line_width) + 18'(line_base);
      clip      = span_end > 18'(screen_width_ff);
      line_ok   = (line_y < 18'(screen_height_ff)) && (line_base < 17'(screen_width_ff))
                  && (req.line_width != 16'd0);
      width_cut = clip ? (screen_width_ff - line_base[11:0]) : req.line_width[11:0];
   end

   always_comb begin
      pix_live    = line_visible_ff && (pos_ff < width_ff);
      idx_sub     = (subst_ff && (req.pixel_value == key_ff)) ? fill_ff : req.pixel_value;
      transparent = skip_ff && (idx_sub == key_ff);
      col         = 13'(base_x_ff) + 13'(pos_ff);

      pix.draw        = (req.op == OP_PIXEL) && pix_live && !transparent;
      pix.in_range    = 9'(idx_sub) < 9'(PALETTE_DEPTH);
      pix.color_index = idx_sub;
      pix.write_x     = col[10:0];
      pix.write_y     = panel_y_ff[10:0];
      pix.run_first   = (run_ff == '0);
   end

   always_comb begin
      line_visible_in = line_visible_ff;
      base_x_in       = base_x_ff;
      panel_y_in      = panel_y_ff;
      width_in        = width_ff;
      pos_in          = pos_ff;
      run_in          = run_ff;
      skip_in         = skip_ff;
      subst_in        = subst_ff;
      key_in          = key_ff;
      fill_in         = fill_ff;
      if (accept) begin
         case (req.op)
            OP_LINE: begin
               line_visible_in = line_ok;
               base_x_in       = line_ok ? line_base[11:0] : 12'd0;
               panel_y_in      = line_ok ? line_y[11:0] : 12'd0;
               width_in        = line_ok ? width_cut : 12'd0;
               pos_in          = 12'd0;
               run_in          = '0;
               key_in          = line_ok ? req.transparent_index : 8'd0;
               fill_in         = line_ok ? req.background_index : 8'd0;
               subst_in        = line_ok && req.restore_background;
               skip_in         = line_ok && req.has_transparency && !req.restore_background;
            end
            OP_PIXEL: begin
               if (pix_live) begin
                  pos_in = pos_ff + 12'd1;
                  if (transparent || (run_ff == RUN_W'(RUN_MAX - 1))) begin
                     run_in = '0;
                  end else begin
                     run_in = run_ff + RUN_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 12'd320;
         screen_height_ff <= 12'd240;
         x_offset_ff      <= 11'd0;
         y_offset_ff      <= 11'd0;
         line_visible_ff  <= 1'b0;
         base_x_ff        <= 12'd0;
         panel_y_ff       <= 12'd0;
         width_ff         <= 12'd0;
         pos_ff           <= 12'd0;
         run_ff           <= '0;
         skip_ff          <= 1'b0;
         subst_ff         <= 1'b0;
         key_ff           <= 8'd0;
         fill_ff          <= 8'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
               CSR_X_OFFSET:      x_offset_ff      <= csr_wdata[10:0];
               CSR_Y_OFFSET:      y_offset_ff      <= csr_wdata[10:0];
               default: begin
               end
            endcase
         end
         line_visible_ff <= line_visible_in;
         base_x_ff       <= base_x_in;
         panel_y_ff      <= panel_y_in;
         width_ff        <= width_in;
         pos_ff          <= pos_in;
         run_ff          <= run_in;
         skip_ff         <= skip_in;
         subst_ff        <= subst_in;
         key_ff          <= key_in;
         fill_ff         <= fill_in;
      end
   end

   `ASSERT_ALWAYS(a_pos_in_width, pos_ff <= width_ff, "pixel position ran past clipped width")
   `ASSERT_ALWAYS(a_dropped_no_draw, !(!line_visible_ff && pix.draw), "draw on a dropped line")
   `ASSERT_NEXT(a_line_clr, accept && (req.op == OP_LINE), pos_ff == '0, "pos not cleared")

endmodule

>>> sv/palette_scanline_run_writer.sv
// palette_scanline_run_writer
//
// Turns indexed scanline items into RGB565 panel pixel writes.
// Request channel (req_valid/req_ready/req_data): palette writes, line starts
// and pixels, one transfer per cycle. Response channel (rsp_valid/rsp_ready/
// rsp_data): at most one pixel write per pixel item, none for transparent,
// clipped or dropped pixels and none for palette writes or line starts.
// Config port (csr_we/csr_index/csr_wdata): panel size and centring offsets;
// write only while no transfer is in flight.
// A drawn pixel appears on rsp in the cycle after its request transfer.
// Throughput: one item per cycle; the palette RAM read and the output
// register are both updated at the request edge, so there is no stall bubble.
// A stalled receiver holds the output register, and req_ready drops until
// the held write is taken (req_ready = !rsp_valid || rsp_ready).
// Reset: panel 320x240, offsets zero, no line active, output empty. The
// palette RAM is not cleared; entries must be written before use.
`include "assert_macros.svh"

module palette_scanline_run_writer
   import psrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   logic    accept;
   pix_type pix;

   // palette access
   logic                  pal_wr_en;
   logic                  pal_rd_en;
   logic [15:0]           pal_rd_data;

   // output register; color comes from the RAM's read register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] write_x_ff;
   logic [10:0] write_y_ff;
   logic        run_first_ff;
   logic        in_range_ff;

   // Accept whenever the output slot is empty or drains this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   psrw_line_ctrl u_line_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pix       (pix)
   );

   // Slots at or past the palette depth are ignored on write.
   assign pal_wr_en = accept && (req_data.op == OP_PALETTE)
                      && (9'(req_data.palette_slot) < 9'(PALETTE_DEPTH));
   // Read only for a drawn pixel so the read register holds during a stall.
   assign pal_rd_en = accept && pix.draw;

   psrw_palette_ram #(
      .DEPTH  (PALETTE_DEPTH),
      .WIDTH  (16),
      .ADDR_W (PAL_ADDR_W)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_data.palette_slot[PAL_ADDR_W-1:0]),
      .wr_data (req_data.palette_color),
      .rd_en   (pal_rd_en),
      .rd_addr (pix.color_index[PAL_ADDR_W-1:0]),
      .rd_data (pal_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = pix.draw;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pal_rd_en) begin
         write_x_ff   <= pix.write_x;
         write_y_ff   <= pix.write_y;
         run_first_ff <= pix.run_first;
         in_range_ff  <= pix.in_range;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.write_x   = write_x_ff;
   assign rsp_data.write_y   = write_y_ff;
   assign rsp_data.color     = in_range_ff ? pal_rd_data : 16'd0;
   assign rsp_data.run_first = run_first_ff;

   `ASSERT_NEXT(a_draw_gives_rsp, accept && pix.draw, rsp_valid_ff, "drawn pixel lost")
   `ASSERT_NEXT(a_nonpixel_no_rsp, accept && (req_data.op != OP_PIXEL), !rsp_valid_ff, "spurious write")
   `ASSERT_NEXT(a_stall_holds, rsp_valid_ff && !rsp_ready, rsp_valid_ff, "held write dropped")

endmodule
